### hw/rtl/spjq_pkg.sv
// ============================================================================
// spjq_pkg
// Shared types, field widths and defaults for the stable priority job queue.
// ============================================================================
package spjq_pkg;

    // Payload field widths (fixed by the stream format)
    localparam int KIND_W   = 1;
    localparam int JOB_ID_W = 16;
    localparam int LEVEL_W  = 2;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 6;

    // Packed stream widths
    localparam int S_TDATA_W = 24;   // job_id, level, zero pad
    localparam int M_TDATA_W = 24;   // out_job_id, out_level, occupancy

    // Parameter defaults
    localparam int DEF_LEVELS      = 3;
    localparam int DEF_LEVEL_DEPTH = 16;
    localparam int DEF_ID_WIDTH    = 16;

    // Request kind
    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } kind_t;

    // Result status
    typedef enum logic [STATUS_W-1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

endpackage

### hw/rtl/stable_priority_job_queue.sv
// ============================================================================
// stable_priority_job_queue
// Priority queue of jobs, FIFO order within each level, one ring per level.
// ============================================================================
//  channel | dir | handshake             | payload
//  s_      | in  | s_tvalid / s_tready   | tuser: kind; tdata: job_id, level
//  m_      | out | m_tvalid / m_tready   | tuser: status;
//          |     |                       | tdata: out_job_id, out_level, occupancy
//
//  One beat in, one beat out; a new request can be taken every cycle unless a result is stalled.
//  The result is registered: pointers and counts update as the request is taken,
//  and the single-port job store returns dequeued data into the result stage.
//  rst_n clears pointers, counts, the total and the result valid flag, not the
//  result payload; the job store is not cleared, since only written slots are read.
//  While a result is stalled on m_tready, s_tready is low.
// ============================================================================
module stable_priority_job_queue #(
    parameter int LEVELS      = spjq_pkg::DEF_LEVELS,
    parameter int LEVEL_DEPTH = spjq_pkg::DEF_LEVEL_DEPTH,
    parameter int ID_WIDTH    = spjq_pkg::DEF_ID_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [spjq_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] job_id, [17:16] level
    input  logic [spjq_pkg::KIND_W-1:0]    s_tuser,   // [0] kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [spjq_pkg::M_TDATA_W-1:0] m_tdata,   // [15:0] out_job_id,
                                                      // [17:16] out_level,
                                                      // [23:18] occupancy
    output logic [spjq_pkg::STATUS_W-1:0]  m_tuser    // [1:0] status
);

    import spjq_pkg::*;

    localparam int PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int SLOTS  = LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int TOT_W  = $clog2(SLOTS + 1);
    localparam int LSEL_W = $clog2(LEVELS);

    // State
    logic [PTR_W-1:0]    head_reg  [LEVELS];
    logic [PTR_W-1:0]    head_next [LEVELS];
    logic [PTR_W-1:0]    tail_reg  [LEVELS];
    logic [PTR_W-1:0]    tail_next [LEVELS];
    logic [CNT_W-1:0]    count_reg [LEVELS];
    logic [CNT_W-1:0]    count_next[LEVELS];
    logic [TOT_W-1:0]    total_reg;
    logic [TOT_W-1:0]    total_next;

    // Result stage
    logic                out_valid_reg;
    logic                out_valid_next;
    status_t             status_reg;
    status_t             status_next;
    logic [LEVEL_W-1:0]  lvl_reg;
    logic [LEVEL_W-1:0]  lvl_next;
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;

    // Request decode
    kind_t               in_kind;
    logic [JOB_ID_W-1:0] in_job;
    logic [LEVEL_W-1:0]  in_level;
    logic [31:0]         in_job_ext;
    logic                accept;
    logic [LEVELS-1:0]   lvl_hit;
    logic                in_range;
    logic [CNT_W-1:0]    enq_cnt;
    logic [PTR_W-1:0]    enq_tail;
    logic                enq_ok;
    logic [LEVELS-1:0]   deq_sel;
    logic [LSEL_W-1:0]   deq_idx;
    logic [PTR_W-1:0]    deq_head;
    logic                deq_found;
    logic                deq_ok;
    logic [LSEL_W-1:0]   op_idx;
    logic [PTR_W-1:0]    op_ptr;

    // Job store port
    logic                ram_en;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [ID_WIDTH-1:0] ram_rdata;
    logic [JOB_ID_W-1:0] out_job;

    assign in_kind    = kind_t'(s_tuser[0]);
    assign in_job     = s_tdata[JOB_ID_W-1:0];
    assign in_level   = s_tdata[JOB_ID_W +: LEVEL_W];
    assign in_job_ext = 32'(in_job);

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Enqueue side: selected level, its fill and tail
    always_comb
    begin
        enq_cnt  = '0;
        enq_tail = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            lvl_hit[i] = (32'(in_level) == i);
            if (lvl_hit[i])
            begin
                enq_cnt  = count_reg[i];
                enq_tail = tail_reg[i];
            end
        end
        in_range = |lvl_hit;
        enq_ok   = (in_kind == KIND_ENQ) && in_range && (enq_cnt < CNT_W'(LEVEL_DEPTH));
    end

    // Dequeue side: most urgent non-empty level
    always_comb
    begin
        deq_sel   = '0;
        deq_idx   = '0;
        deq_head  = '0;
        deq_found = 1'b0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (!deq_found && (count_reg[i] != '0))
            begin
                deq_sel[i] = 1'b1;
                deq_idx    = LSEL_W'(i);
                deq_head   = head_reg[i];
                deq_found  = 1'b1;
            end
        end
        deq_ok = (in_kind == KIND_DEQ) && deq_found;
    end

    // Store address: level base plus ring pointer
    assign op_idx   = (in_kind == KIND_DEQ) ? deq_idx : LSEL_W'(in_level);
    assign op_ptr   = (in_kind == KIND_DEQ) ? deq_head : enq_tail;
    assign ram_addr = ADDR_W'(ADDR_W'(op_idx) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(op_ptr));
    assign ram_en   = accept && (enq_ok || deq_ok);
    assign ram_we   = enq_ok;

    // Pointer, count and total update
    always_comb
    begin
        total_next = total_reg;
        for (int i = 0; i < LEVELS; i++)
        begin
            head_next[i]  = head_reg[i];
            tail_next[i]  = tail_reg[i];
            count_next[i] = count_reg[i];
            if (accept && enq_ok && lvl_hit[i])
            begin
                tail_next[i]  = (tail_reg[i] == PTR_W'(LEVEL_DEPTH - 1)) ? '0
                              : tail_reg[i] + 1'b1;
                count_next[i] = count_reg[i] + 1'b1;
            end
            if (accept && deq_ok && deq_sel[i])
            begin
                head_next[i]  = (head_reg[i] == PTR_W'(LEVEL_DEPTH - 1)) ? '0
                              : head_reg[i] + 1'b1;
                count_next[i] = count_reg[i] - 1'b1;
            end
        end
        if (accept && enq_ok)
        begin
            total_next = total_reg + 1'b1;
        end
        else if (accept && deq_ok)
        begin
            total_next = total_reg - 1'b1;
        end
    end

    // Result stage next values
    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        lvl_next       = lvl_reg;
        occ_next       = occ_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            occ_next       = OCC_W'(total_next);
            lvl_next       = '0;
            if (in_kind == KIND_DEQ)
            begin
                status_next = deq_ok ? ST_DEQ : ST_EMPTY;
                if (deq_ok)
                begin
                    lvl_next = LEVEL_W'(deq_idx);
                end
            end
            else
            begin
                status_next = enq_ok ? ST_ENQ : ST_FULL;
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        lvl_reg    <= lvl_next;
        occ_reg    <= occ_next;
    end

    // Job store
    spjq_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (SLOTS)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_job_ext[ID_WIDTH-1:0]),
        .rdata (ram_rdata)
    );

    // Outputs
    assign out_job  = (status_reg == ST_DEQ) ? JOB_ID_W'(ram_rdata) : '0;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {occ_reg, lvl_reg, out_job};

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    logic [TOT_W-1:0] count_sum;

    always_comb
    begin
        count_sum = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            count_sum = count_sum + TOT_W'(count_reg[i]);
        end
    end

    // Running total tracks the per-level fills
    a_total_sum: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg == count_sum)
        else $error("total does not match level counts");

    // An empty result only when nothing is held
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_EMPTY) |-> (occ_reg == '0))
        else $error("empty reported with jobs held");

    // A taken enqueue grows the total by one
    a_enq_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && enq_ok) |=> (total_reg == $past(total_reg) + 1'b1))
        else $error("enqueue did not grow total");

    // A taken dequeue reports a job and shrinks the total by one
    a_deq_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && deq_ok) |=> (status_reg == ST_DEQ
                                && total_reg == $past(total_reg) - 1'b1))
        else $error("dequeue did not shrink total");

    // Full drop leaves the target level full or the level out of range
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_kind == KIND_ENQ && !enq_ok)
            |-> (!in_range || enq_cnt == CNT_W'(LEVEL_DEPTH)))
        else $error("enqueue dropped with room left");

endmodule

### hw/rtl/spjq_ram.sv
// ============================================================================
// spjq_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ============================================================================
module spjq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, or read into the output register; rdata holds otherwise
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### tb/stable_priority_job_queue_tb.sv
// ============================================================================
// stable_priority_job_queue_tb
// Self-checking bench for the stable priority job queue. A short table of
// directed requests covers the empty queue, out-of-range levels, field
// extremes and ordering within and across levels. A long random run follows
// in fill, drain and mixed phases, so that levels overflow and drain. Every
// result beat is checked against an expected beat from the table or from a
// queue model held in the bench. Both stream sides idle at random.
// ============================================================================
module stable_priority_job_queue_tb;

    import spjq_pkg::*;

    localparam int LEVELS      = DEF_LEVELS;
    localparam int LEVEL_DEPTH = DEF_LEVEL_DEPTH;
    localparam int RANDOM_REQS = 1030;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 4;

    // One result beat, fields as carried on m_tuser / m_tdata
    typedef struct packed {
        status_t     status;
        logic [15:0] job_id;
        logic [1:0]  level;
        logic [5:0]  occupancy;
    } outcome_t;

    // One row of the directed table
    typedef struct packed {
        kind_t       kind;
        logic [15:0] job_id;
        logic [1:0]  level;
        bit          typed;
        outcome_t    outcome;
    } request_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // Queue model: one ring of job ids per level
    logic [15:0] ring_ids [LEVELS][LEVEL_DEPTH];
    int unsigned rd_slot [LEVELS];
    int unsigned wr_slot [LEVELS];
    int unsigned jobs_held [LEVELS];

    outcome_t     outcomes_due [$];
    request_row_t directed_rows [$];
    int           errors = 0;
    int           cycle_count = 0;
    bit           quiet = 1'b0;

    stable_priority_job_queue uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Applies one request to the model and returns the beat it should give
    function automatic outcome_t serve_request(kind_t kind, logic [15:0] id,
                                               logic [1:0] lvl);
        outcome_t    res;
        bit          found;
        int unsigned total;
        res   = '0;
        found = 1'b0;
        total = 0;
        if (kind == KIND_ENQ)
        begin
            if (lvl >= LEVELS)
                res.status = ST_FULL;
            else if (jobs_held[lvl] >= LEVEL_DEPTH)
                res.status = ST_FULL;
            else
            begin
                ring_ids[lvl][wr_slot[lvl]] = id;
                wr_slot[lvl]   = (wr_slot[lvl] + 1) % LEVEL_DEPTH;
                jobs_held[lvl] = jobs_held[lvl] + 1;
                res.status     = ST_ENQ;
            end
        end
        else
        begin
            res.status = ST_EMPTY;
            for (int i = 0; i < LEVELS; i++)
            begin
                if (!found && jobs_held[i] > 0)
                begin
                    res.job_id   = ring_ids[i][rd_slot[i]];
                    res.level    = 2'(i);
                    rd_slot[i]   = (rd_slot[i] + 1) % LEVEL_DEPTH;
                    jobs_held[i] = jobs_held[i] - 1;
                    res.status   = ST_DEQ;
                    found        = 1'b1;
                end
            end
        end
        for (int i = 0; i < LEVELS; i++)
            total += jobs_held[i];
        res.occupancy = 6'(total);
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic void add_row(kind_t kind, logic [15:0] id, logic [1:0] lvl,
                                    bit typed, status_t st, logic [15:0] out_id,
                                    logic [1:0] out_lvl, logic [5:0] occ);
        request_row_t row;
        row.kind              = kind;
        row.job_id            = id;
        row.level             = lvl;
        row.typed             = typed;
        row.outcome.status    = st;
        row.outcome.job_id    = out_id;
        row.outcome.level     = out_lvl;
        row.outcome.occupancy = occ;
        directed_rows.push_back(row);
    endfunction

    // Drive one request beat from a falling edge; returns at a falling edge
    task automatic send_request(kind_t kind, logic [15:0] id, logic [1:0] lvl,
                                bit typed, outcome_t typed_outcome);
        int       gap;
        outcome_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, lvl, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = serve_request(kind, id, lvl);
        outcomes_due.push_back(typed ? typed_outcome : predicted);
        @(negedge clk);
    endtask

    // Result side back-pressure
    initial
    begin
        int run_left;
        int stall_left;
        run_left   = 0;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet)
                m_tready <= 1'b1;
            else if (run_left > 0)
            begin
                m_tready <= 1'b1;
                run_left--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                run_left   = $urandom_range(1, 24);
                stall_left = pick_gap();
                m_tready <= 1'b1;
            end
        end
    end

    // Result beat check against the oldest outstanding outcome
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (outcomes_due.size() == 0)
            begin
                $error("result beat with no request outstanding");
                errors++;
            end
            else
            begin
                want = outcomes_due.pop_front();
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    errors++;
                end
                if (m_tdata[15:0] !== want.job_id)
                begin
                    $error("out_job_id: expected %0h, got %0h", want.job_id,
                           m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[17:16] !== want.level)
                begin
                    $error("out_level: expected %0d, got %0d", want.level,
                           m_tdata[17:16]);
                    errors++;
                end
                if (m_tdata[23:18] !== want.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy,
                           m_tdata[23:18]);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int          sent;
        int          phase_len;
        int          enq_pct;
        int          favoured;
        int          r;
        kind_t       kind;
        logic [15:0] id;
        logic [1:0]  lvl;

        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_ENQ;
        rst_n    = 1'b0;
        for (int i = 0; i < LEVELS; i++)
        begin
            rd_slot[i]   = 0;
            wr_slot[i]   = 0;
            jobs_held[i] = 0;
        end

        // kind, job_id, level, typed, status, out_job_id, out_level, occupancy
        add_row(KIND_DEQ, 16'hFFFF, 2'd3, 1, ST_EMPTY, 16'h0000, 2'd0, 6'd0);
        add_row(KIND_ENQ, 16'hFFFF, 2'd2, 1, ST_ENQ,   16'h0000, 2'd0, 6'd1);
        add_row(KIND_ENQ, 16'h0000, 2'd1, 1, ST_ENQ,   16'h0000, 2'd0, 6'd2);
        add_row(KIND_ENQ, 16'h8001, 2'd0, 1, ST_ENQ,   16'h0000, 2'd0, 6'd3);
        add_row(KIND_ENQ, 16'h1234, 2'd3, 1, ST_FULL,  16'h0000, 2'd0, 6'd3);
        add_row(KIND_DEQ, 16'h0000, 2'd0, 1, ST_DEQ,   16'h8001, 2'd0, 6'd2);
        add_row(KIND_DEQ, 16'hAAAA, 2'd1, 1, ST_DEQ,   16'h0000, 2'd1, 6'd1);
        add_row(KIND_ENQ, 16'h00AA, 2'd2, 0, ST_ENQ,   16'h0000, 2'd0, 6'd0);
        add_row(KIND_ENQ, 16'h5555, 2'd0, 0, ST_ENQ,   16'h0000, 2'd0, 6'd0);
        add_row(KIND_ENQ, 16'hAAAA, 2'd0, 0, ST_ENQ,   16'h0000, 2'd0, 6'd0);
        add_row(KIND_DEQ, 16'h5555, 2'd2, 0, ST_ENQ,   16'h0000, 2'd0, 6'd0);
        add_row(KIND_DEQ, 16'h0000, 2'd0, 0, ST_ENQ,   16'h0000, 2'd0, 6'd0);
        add_row(KIND_DEQ, 16'h0000, 2'd0, 0, ST_ENQ,   16'h0000, 2'd0, 6'd0);
        add_row(KIND_DEQ, 16'h0000, 2'd0, 0, ST_ENQ,   16'h0000, 2'd0, 6'd0);
        add_row(KIND_DEQ, 16'h0000, 2'd0, 1, ST_EMPTY, 16'h0000, 2'd0, 6'd0);
        add_row(KIND_ENQ, 16'h7FFF, 2'd3, 1, ST_FULL,  16'h0000, 2'd0, 6'd0);
        add_row(KIND_ENQ, 16'h0001, 2'd2, 0, ST_ENQ,   16'h0000, 2'd0, 6'd0);
        add_row(KIND_ENQ, 16'hFFFE, 2'd1, 0, ST_ENQ,   16'h0000, 2'd0, 6'd0);
        add_row(KIND_ENQ, 16'h0002, 2'd2, 0, ST_ENQ,   16'h0000, 2'd0, 6'd0);
        add_row(KIND_DEQ, 16'h0000, 2'd0, 0, ST_ENQ,   16'h0000, 2'd0, 6'd0);
        add_row(KIND_DEQ, 16'h0000, 2'd0, 0, ST_ENQ,   16'h0000, 2'd0, 6'd0);
        add_row(KIND_DEQ, 16'h0000, 2'd0, 0, ST_ENQ,   16'h0000, 2'd0, 6'd0);

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        foreach (directed_rows[i])
            send_request(directed_rows[i].kind, directed_rows[i].job_id,
                         directed_rows[i].level, directed_rows[i].typed,
                         directed_rows[i].outcome);

        // Random phases: fill, drain and mixed, some with no idling at all
        sent = 0;
        while (sent < RANDOM_REQS)
        begin
            r         = $urandom_range(3);
            enq_pct   = (r == 0) ? 85 : (r == 1) ? 20 : 50;
            favoured  = $urandom_range(LEVELS - 1);
            phase_len = $urandom_range(30, 120);
            quiet     = (r == 3) || ($urandom_range(4) == 0);
            for (int n = 0; n < phase_len && sent < RANDOM_REQS; n++)
            begin
                kind = ($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
                r    = $urandom_range(99);
                if (r < 4)
                    id = 16'h0000;
                else if (r < 8)
                    id = 16'hFFFF;
                else
                    id = 16'($urandom());
                r = $urandom_range(99);
                if (r < 6)
                    lvl = 2'd3;
                else if (r < 60)
                    lvl = 2'(favoured);
                else
                    lvl = 2'($urandom_range(LEVELS - 1));
                send_request(kind, id, lvl, 1'b0, '0);
                sent++;
            end
        end
        s_tvalid <= 1'b0;
        quiet = 1'b0;

        // Let outstanding results drain, then watch for stray beats
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
